// ===== src/pfe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pfe_pkg;

  localparam int unsigned SqSize = 5;

  typedef logic [4:0]  letter_t;
  typedef logic [2:0]  sq_idx_t;
  typedef logic [24:0] key_row_t;
  typedef key_row_t [SqSize-1:0] key_sq_t;

  // Bytes of interest
  localparam logic [7:0] CharUpA = 8'd65;
  localparam logic [7:0] CharUpZ = 8'd90;
  localparam logic [7:0] CharLoA = 8'd97;
  localparam logic [7:0] CharLoZ = 8'd122;
  localparam logic [6:0] AsciiA  = 7'd65;

  localparam letter_t LetI = 5'd8;
  localparam letter_t LetJ = 5'd9;
  localparam letter_t LetX = 5'd23;

  // Config register indexes
  localparam logic [2:0] RegKeyRow0 = 3'd0;
  localparam logic [2:0] RegKeyRow4 = 3'd4;

  // Reset square MFHIK / UNOPQ / ZVWXY / ELARG / DSTBC
  localparam key_row_t KeyRow0Rst = 25'd10755244;
  localparam key_row_t KeyRow1Rst = 25'd17283508;
  localparam key_row_t KeyRow2Rst = 25'd25942713;
  localparam key_row_t KeyRow3Rst = 25'd6848868;
  localparam key_row_t KeyRow4Rst = 25'd2149955;

  // One queue entry: up to two pairs from one input byte.
  // Second pair, when present, is always (a1, X).
  typedef struct packed {
    letter_t a0;
    letter_t b0;
    letter_t a1;
    logic    two;
    logic    fin;
  } pair_job_t;

  typedef struct packed {
    sq_idx_t row;
    sq_idx_t col;
  } sq_loc_t;

  function automatic letter_t cell_at(key_sq_t sq, sq_idx_t r, sq_idx_t c);
    letter_t v;
    v = '0;
    unique case (c)
      3'd0:    v = sq[r][4:0];
      3'd1:    v = sq[r][9:5];
      3'd2:    v = sq[r][14:10];
      3'd3:    v = sq[r][19:15];
      3'd4:    v = sq[r][24:20];
      default: v = '0;
    endcase
    return v;
  endfunction

  // First match in row-major order wins; a missing letter lands at (0,0).
  function automatic sq_loc_t locate(key_sq_t sq, letter_t code);
    sq_loc_t l;
    l = '0;
    for (int r = SqSize - 1; r >= 0; r--) begin
      for (int c = SqSize - 1; c >= 0; c--) begin
        if (sq[r][c*5 +: 5] == code) begin
          l.row = sq_idx_t'(r);
          l.col = sq_idx_t'(c);
        end
      end
    end
    return l;
  endfunction

  function automatic sq_idx_t inc_wrap(sq_idx_t v);
    return (v == sq_idx_t'(SqSize - 1)) ? '0 : sq_idx_t'(v + 3'd1);
  endfunction

  function automatic logic [6:0] to_ascii(letter_t code);
    return 7'(AsciiA + {2'b00, code});
  endfunction

endpackage

`default_nettype wire

// ===== src/pfe_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfe_front
  import pfe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_xfer_i,
  input  wire logic [7:0] in_char_i,
  input  wire logic      in_end_i,
  output pair_job_t      job_o,
  output logic           push_o
);

  letter_t held_q, held_d;
  logic    held_v_q, held_v_d;

  logic    is_up, is_lo, is_letter;
  letter_t code, raw_code;
  letter_t mid_held;
  logic    mid_v;
  logic    first_pair, end_pair;

  always_comb begin
    is_up     = (in_char_i >= CharUpA) && (in_char_i <= CharUpZ);
    is_lo     = (in_char_i >= CharLoA) && (in_char_i <= CharLoZ);
    is_letter = is_up || is_lo;
    raw_code  = is_up ? letter_t'(in_char_i - CharUpA) : letter_t'(in_char_i - CharLoA);
    code      = (raw_code == LetJ) ? LetI : raw_code;

    first_pair = is_letter && held_v_q;
    mid_held   = held_q;
    mid_v      = held_v_q;
    if (is_letter) begin
      if (held_v_q) begin
        // doubled letter keeps itself held, otherwise the pair closes
        mid_v = (held_q == code);
      end else begin
        mid_held = code;
        mid_v    = 1'b1;
      end
    end
    end_pair = in_end_i && mid_v;

    job_o.fin = in_end_i;
    if (first_pair) begin
      job_o.a0  = held_q;
      job_o.b0  = (held_q == code) ? LetX : code;
      job_o.a1  = mid_held;
      job_o.two = end_pair;
    end else begin
      job_o.a0  = mid_held;
      job_o.b0  = LetX;
      job_o.a1  = mid_held;
      job_o.two = 1'b0;
    end
    push_o = in_xfer_i && (first_pair || end_pair);

    held_d   = held_q;
    held_v_d = held_v_q;
    if (in_xfer_i) begin
      held_d   = mid_held;
      held_v_d = mid_v && !in_end_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q   <= '0;
      held_v_q <= 1'b0;
    end else begin
      held_q   <= held_d;
      held_v_q <= held_v_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfe_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfe_fifo
  import pfe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire pair_job_t data_i,
  output logic           full_o,
  input  wire logic      pop_i,
  output pair_job_t      data_o,
  output logic           empty_o
);

  pair_job_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i  ? !rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = 2'(cnt_q + 2'd1);
    end else if (pop_i && !push_i) begin
      cnt_d = 2'(cnt_q - 2'd1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/pfe_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pfe_back
  import pfe_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire key_sq_t   key_i,
  input  wire pair_job_t job_i,
  input  wire logic      job_empty_i,
  output logic           pop_o,
  output logic [6:0]     letter_o,
  output logic           last_o,
  output logic           valid_o,
  input  wire logic      ready_i
);

  // pair select
  logic    sub_q, sub_d;
  letter_t pa, pb;
  logic    last_pair, take;

  // locate stage
  logic    l_v_q, l_v_d;
  sq_loc_t l1_q, l2_q;
  logic    l_fin_q;

  // output stage, two letters per pair
  logic       o_v_q, o_v_d;
  logic       o_idx_q, o_idx_d;
  logic [6:0] o_let0_q, o_let1_q;
  logic       o_fin_q;
  logic       o_load, o_free;
  letter_t    e1, e2;

  always_comb begin
    pa        = sub_q ? job_i.a1 : job_i.a0;
    pb        = sub_q ? LetX     : job_i.b0;
    last_pair = sub_q || !job_i.two;

    o_free = !o_v_q || (o_idx_q && ready_i);
    o_load = l_v_q && o_free;
    take   = !job_empty_i && (!l_v_q || o_load);
    pop_o  = take && last_pair;
    sub_d  = take ? !last_pair : sub_q;
    l_v_d  = take || (l_v_q && !o_load);

    if (l1_q.row == l2_q.row) begin
      e1 = cell_at(key_i, l1_q.row, inc_wrap(l1_q.col));
      e2 = cell_at(key_i, l2_q.row, inc_wrap(l2_q.col));
    end else if (l1_q.col == l2_q.col) begin
      e1 = cell_at(key_i, inc_wrap(l1_q.row), l1_q.col);
      e2 = cell_at(key_i, inc_wrap(l2_q.row), l2_q.col);
    end else begin
      e1 = cell_at(key_i, l1_q.row, l2_q.col);
      e2 = cell_at(key_i, l2_q.row, l1_q.col);
    end

    o_v_d   = o_v_q;
    o_idx_d = o_idx_q;
    if (o_load) begin
      o_v_d   = 1'b1;
      o_idx_d = 1'b0;
    end else if (o_v_q && ready_i) begin
      o_v_d   = !o_idx_q;
      o_idx_d = 1'b1;
    end
  end

  assign valid_o  = o_v_q;
  assign letter_o = o_idx_q ? o_let1_q : o_let0_q;
  assign last_o   = o_idx_q && o_fin_q;

  always_ff @(posedge clk_i) begin
    if (take) begin
      l1_q    <= locate(key_i, pa);
      l2_q    <= locate(key_i, pb);
      l_fin_q <= last_pair && job_i.fin;
    end
    if (o_load) begin
      o_let0_q <= to_ascii(e1);
      o_let1_q <= to_ascii(e2);
      o_fin_q  <= l_fin_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sub_q   <= 1'b0;
      l_v_q   <= 1'b0;
      o_v_q   <= 1'b0;
      o_idx_q <= 1'b0;
    end else begin
      sub_q   <= sub_d;
      l_v_q   <= l_v_d;
      o_v_q   <= o_v_d;
      o_idx_q <= o_idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== src/playfair_stream_encrypt_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  | Dir | Handshake                     | Payload
// ---------+-----+-------------------------------+-------------------------------------
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tdata = in_char, tlast = message_end
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata = cipher_letter, tlast = final_result
// cfg      | in  | cfg_we_i (no wait)            | cfg_index_i, cfg_wdata_i = key row
//
// Input bytes are taken one per cycle while the two-entry pair queue has room.
// Each pair leaves as two letters, one after the other, from the output register.
// After the closing byte's transfer, the first letter passes through the pair
// queue, the locate registers and the output register before it can leave.
// Reset clears the held letter, the queue and the pipeline valids and loads the
// default key square. A stalled output only backs up into the queue; the front
// keeps taking bytes until the queue fills.

module playfair_stream_encrypt_core
  import pfe_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_char
  input  wire logic        s_axis_tlast,   // message_end

  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [6:0] cipher_letter, [7] zero
  output logic             m_axis_tlast,   // final_result

  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_index_i,
  input  wire logic [24:0] cfg_wdata_i
);

  key_sq_t    key_q;
  pair_job_t  push_job, head_job;
  logic       fifo_push, fifo_full, fifo_pop, fifo_empty;
  logic       in_xfer;
  logic [6:0] out_letter;

  // Key square registers; indexes past the last row are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q[0] <= KeyRow0Rst;
      key_q[1] <= KeyRow1Rst;
      key_q[2] <= KeyRow2Rst;
      key_q[3] <= KeyRow3Rst;
      key_q[4] <= KeyRow4Rst;
    end else if (cfg_we_i && (cfg_index_i <= RegKeyRow4)) begin
      key_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  assign s_axis_tready = !fifo_full;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // Front: letter filter, pairing, X insertion and end padding
  pfe_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_xfer_i (in_xfer),
    .in_char_i (s_axis_tdata),
    .in_end_i  (s_axis_tlast),
    .job_o     (push_job),
    .push_o    (fifo_push)
  );

  // Pair queue between front and back
  pfe_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (push_job),
    .full_o  (fifo_full),
    .pop_i   (fifo_pop),
    .data_o  (head_job),
    .empty_o (fifo_empty)
  );

  // Back: locate in the square, apply the row/column/rectangle rule, serialize
  pfe_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .job_i       (head_job),
    .job_empty_i (fifo_empty),
    .pop_o       (fifo_pop),
    .letter_o    (out_letter),
    .last_o      (m_axis_tlast),
    .valid_o     (m_axis_tvalid),
    .ready_i     (m_axis_tready)
  );

  assign m_axis_tdata = {1'b0, out_letter};

  // Front must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_push |-> !fifo_full)
    else $error("pair queue overflow");

  // Back must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fifo_pop |-> !fifo_empty)
    else $error("pair queue underflow");

  // A final letter is the second of its pair, so the one before it was also shown.
  a_last_second: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tlast) |-> $past(m_axis_tvalid))
    else $error("final letter without its partner");

endmodule

`default_nettype wire
